// File: hw/rtl/tbpc_pkg.sv
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared constants, types and the rotator angle table of the pilot correlator.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    localparam int TAPS    = 128;
    localparam int TAP_W   = $clog2(TAPS);
    localparam int ACC_W   = 34 + TAP_W;
    localparam int FILTERS = 6;

    localparam logic REG_PHASE_STEP   = 1'b0;
    localparam logic REG_OUTPUT_SHIFT = 1'b1;

    typedef struct packed {
        logic shift_in;
        logic rotate;
    } cell_ctrl_t;

    typedef logic signed [15:0] samp_t;

    function automatic logic signed [33:0] arc_angle(input logic [3:0] i);
        logic signed [33:0] a;
        case (i)
            4'd0:    a = 34'sd536870912;
            4'd1:    a = 34'sd316933406;
            4'd2:    a = 34'sd167458907;
            4'd3:    a = 34'sd85004756;
            4'd4:    a = 34'sd42667333;
            4'd5:    a = 34'sd21354465;
            4'd6:    a = 34'sd10679838;
            4'd7:    a = 34'sd5340244;
            4'd8:    a = 34'sd2670161;
            4'd9:    a = 34'sd1335085;
            4'd10:   a = 34'sd667544;
            4'd11:   a = 34'sd333772;
            4'd12:   a = 34'sd166886;
            4'd13:   a = 34'sd83443;
            4'd14:   a = 34'sd41722;
            default: a = 34'sd20861;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/tbpc_cell.sv
// ----------------------------------------------------------------------------
// tbpc_cell
// One history cell: takes a sample from the left on a new beat, circulates
// towards the head during a correlation pass.
// ----------------------------------------------------------------------------
module tbpc_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tbpc_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]          prev_data,
    input  logic [31:0]          next_data,
    output logic [31:0]          data
);

    logic [31:0] data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg <= '0;
        end else if (ctrl.shift_in) begin
            data_reg <= prev_data;
        end else if (ctrl.rotate) begin
            data_reg <= next_data;
        end
    end

    assign data = data_reg;

endmodule

// File: hw/rtl/tbpc_cordic.sv
// ----------------------------------------------------------------------------
// tbpc_cordic
// Iterative 16-step rotator with gain correction and 16-bit saturation.
// ----------------------------------------------------------------------------
module tbpc_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [15:0]    in_re,
    input  logic signed [15:0]    in_im,
    input  logic [31:0]           phase,
    output logic                  done,
    output logic signed [15:0]    out_re,
    output logic signed [15:0]    out_im
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_GAIN = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    logic [1:0]         state_reg;
    logic               done_reg;
    logic [3:0]         iter_reg;
    logic               bypass_reg;
    logic signed [15:0] re_reg, im_reg, ore_reg, oim_reg;
    logic signed [35:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic signed [51:0] px_reg, py_reg;

    logic               quad;
    logic [31:0]        ph2;
    logic signed [35:0] xs, ys, sx, sy;
    logic signed [51:0] rx, ry;

    function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
        logic signed [15:0] r;
        if (v > 52'sd32767) r = 16'sh7fff;
        else if (v < -52'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic ph2_sum_bit(input logic [31:0] p);
        logic [31:0] s;
        s = p + 32'h4000_0000;
        return s[31];
    endfunction

    always_comb begin
        quad = ph2_sum_bit(phase);
        ph2  = quad ? phase + 32'h8000_0000 : phase;
        xs   = 36'(in_re) <<< 16;
        ys   = 36'(in_im) <<< 16;
        sx   = x_reg >>> iter_reg;
        sy   = y_reg >>> iter_reg;
        rx   = (px_reg + 52'sd1073741824) >>> 31;
        ry   = (py_reg + 52'sd1073741824) >>> 31;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        re_reg     <= in_re;
                        im_reg     <= in_im;
                        bypass_reg <= (phase == 32'd0);
                        x_reg      <= quad ? -xs : xs;
                        y_reg      <= quad ? -ys : ys;
                        z_reg      <= 34'(signed'(ph2));
                        iter_reg   <= '0;
                        state_reg  <= (phase == 32'd0) ? C_FIN : C_RUN;
                    end
                end
                C_RUN: begin
                    if (!z_reg[33]) begin
                        x_reg <= x_reg - sy;
                        y_reg <= y_reg + sx;
                        z_reg <= z_reg - tbpc_pkg::arc_angle(iter_reg);
                    end else begin
                        x_reg <= x_reg + sy;
                        y_reg <= y_reg - sx;
                        z_reg <= z_reg + tbpc_pkg::arc_angle(iter_reg);
                    end
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'd15) state_reg <= C_GAIN;
                end
                C_GAIN: begin
                    px_reg    <= 52'(x_reg) * 52'sd19898;
                    py_reg    <= 52'(y_reg) * 52'sd19898;
                    state_reg <= C_FIN;
                end
                C_FIN: begin
                    ore_reg   <= bypass_reg ? re_reg : sat16(rx);
                    oim_reg   <= bypass_reg ? im_reg : sat16(ry);
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign out_re = ore_reg;
    assign out_im = oim_reg;

endmodule

// File: hw/rtl/three_band_pilot_correlator.sv
// ----------------------------------------------------------------------------
// three_band_pilot_correlator
// Six-filter complex correlator: two templates in three frequency bands,
// history held in a circulating chain of cells, power per received sample.
// ----------------------------------------------------------------------------
// channel   direction  content
// s_*       in         tuser: kind; tdata: tap_index, template_select, re, im
// m_*       out        tdata: six 48-bit band powers
// cfg_*     in         phase_step, output_shift writes
//
// a sample makes one pass of the history chain past the two tap memory read ports,
// then a pipeline drain, saturation, squaring and output load
// a tap write runs through the iterative rotators, bypassed when its phase is zero
// reset clears the history chain at once; taps are undefined until written
// a sample is taken while the previous result waits; the final step stalls
// until the output register is free
module three_band_pilot_correlator (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // tap_index, template_select, data_re, data_im
    input  logic [0:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [287:0] m_tdata,   // power_t0_low_band, power_t1_low_band,
                                    // power_t0_mid_band, power_t1_mid_band,
                                    // power_t0_high_band, power_t1_high_band
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [30:0]  cfg_wdata
);

    localparam int TAPS  = tbpc_pkg::TAPS;
    localparam int TAP_W = tbpc_pkg::TAP_W;
    localparam int ACC_W = tbpc_pkg::ACC_W;
    localparam int NF    = tbpc_pkg::FILTERS;

    localparam logic REG_PHASE_STEP_C   = tbpc_pkg::REG_PHASE_STEP;
    localparam logic REG_OUTPUT_SHIFT_C = tbpc_pkg::REG_OUTPUT_SHIFT;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PHASE = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_ROT   = 4'd3;
    localparam logic [3:0] S_CALC  = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_SAT   = 4'd6;
    localparam logic [3:0] S_SQR   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]        state_reg;
    logic [30:0]       phase_step_reg;
    logic [4:0]        output_shift_reg;
    logic [TAP_W-1:0]  cnt_reg;
    logic [6:0]        idx_reg;
    logic              sel_reg;
    logic signed [15:0] tre_reg, tim_reg;
    logic [31:0]       ph_reg;
    logic              pa_valid_reg, pb_valid_reg;
    logic [31:0]       hist_a_reg;
    logic [95:0]       tap_a_reg [2];
    logic signed [31:0] p_rr_reg [NF], p_ii_reg [NF], p_ri_reg [NF], p_ir_reg [NF];
    logic signed [ACC_W-1:0] acc_r_reg [NF], acc_i_reg [NF];
    logic signed [23:0] sr_reg [NF], si_reg [NF];
    logic [47:0]       sq_r_reg [NF], sq_i_reg [NF];
    logic              m_tvalid_reg;
    logic [287:0]      m_tdata_reg;

    logic [95:0]       mem0 [TAPS];
    logic [95:0]       mem1 [TAPS];

    logic              accept;
    tbpc_pkg::cell_ctrl_t cctrl;
    logic [31:0]       cell_data [TAPS];
    logic              done_lo, done_hi;
    logic signed [15:0] lo_re, lo_im, hi_re, hi_im;
    logic              out_free;

    function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
        logic signed [23:0] r;
        if (v > ACC_W'(8388607)) r = 24'sh7fffff;
        else if (v < -ACC_W'(8388608)) r = 24'sh800000;
        else r = v[23:0];
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign cctrl.shift_in = accept && s_tuser[0];
    assign cctrl.rotate   = (state_reg == S_CALC);

    genvar g;
    generate
        for (g = 0; g < TAPS; g++) begin : g_chain
            tbpc_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (cctrl),
                .prev_data ((g == 0) ? {s_tdata[39:24], s_tdata[23:8]}
                                     : cell_data[(g + TAPS - 1) % TAPS]),
                .next_data (cell_data[(g + 1) % TAPS]),
                .data      (cell_data[g])
            );
        end
    endgenerate

    tbpc_cordic u_rot_lo (
        .aclk (aclk), .aresetn (aresetn), .start (state_reg == S_START),
        .in_re (tre_reg), .in_im (tim_reg), .phase (32'd0 - ph_reg),
        .done (done_lo), .out_re (lo_re), .out_im (lo_im)
    );

    tbpc_cordic u_rot_hi (
        .aclk (aclk), .aresetn (aresetn), .start (state_reg == S_START),
        .in_re (tre_reg), .in_im (tim_reg), .phase (ph_reg),
        .done (done_hi), .out_re (hi_re), .out_im (hi_im)
    );

    // tap memories, one per template, word holds low, mid, high band
    always_ff @(posedge aclk) begin
        if (state_reg == S_ROT && done_lo && 32'(idx_reg) < TAPS) begin
            if (sel_reg) begin
                mem1[idx_reg[TAP_W-1:0]] <= {hi_im, hi_re, tim_reg, tre_reg, lo_im, lo_re};
            end else begin
                mem0[idx_reg[TAP_W-1:0]] <= {hi_im, hi_re, tim_reg, tre_reg, lo_im, lo_re};
            end
        end
        if (state_reg == S_CALC) begin
            tap_a_reg[0] <= mem0[cnt_reg];
            tap_a_reg[1] <= mem1[cnt_reg];
            hist_a_reg   <= cell_data[0];
        end
    end

    // products, accumulation, saturation, squaring and output power
    always_ff @(posedge aclk) begin
        for (int f = 0; f < NF; f++) begin
            p_rr_reg[f] <= signed'(tap_a_reg[f % 2][(f / 2) * 32 +: 16])
                           * signed'(hist_a_reg[15:0]);
            p_ii_reg[f] <= signed'(tap_a_reg[f % 2][(f / 2) * 32 + 16 +: 16])
                           * signed'(hist_a_reg[31:16]);
            p_ri_reg[f] <= signed'(tap_a_reg[f % 2][(f / 2) * 32 +: 16])
                           * signed'(hist_a_reg[31:16]);
            p_ir_reg[f] <= signed'(tap_a_reg[f % 2][(f / 2) * 32 + 16 +: 16])
                           * signed'(hist_a_reg[15:0]);
            if (accept) begin
                acc_r_reg[f] <= '0;
                acc_i_reg[f] <= '0;
            end else if (pb_valid_reg) begin
                acc_r_reg[f] <= acc_r_reg[f] + ACC_W'(p_rr_reg[f]) - ACC_W'(p_ii_reg[f]);
                acc_i_reg[f] <= acc_i_reg[f] + ACC_W'(p_ri_reg[f]) + ACC_W'(p_ir_reg[f]);
            end
            if (state_reg == S_SAT) begin
                sr_reg[f] <= sat24(acc_r_reg[f] >>> output_shift_reg);
                si_reg[f] <= sat24(acc_i_reg[f] >>> output_shift_reg);
            end
            if (state_reg == S_SQR) begin
                sq_r_reg[f] <= 48'(48'(sr_reg[f]) * 48'(sr_reg[f]));
                sq_i_reg[f] <= 48'(48'(si_reg[f]) * 48'(si_reg[f]));
            end
            if (state_reg == S_OUT && out_free) begin
                m_tdata_reg[f * 48 +: 48] <= sq_r_reg[f] + sq_i_reg[f];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            phase_step_reg   <= 31'd6883019;
            output_shift_reg <= 5'd16;
            pa_valid_reg     <= 1'b0;
            pb_valid_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            cnt_reg          <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_PHASE_STEP_C:   phase_step_reg   <= cfg_wdata;
                    REG_OUTPUT_SHIFT_C: output_shift_reg <= cfg_wdata[4:0];
                    default:            ;
                endcase
            end
            pa_valid_reg <= (state_reg == S_CALC);
            pb_valid_reg <= pa_valid_reg;
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        idx_reg <= s_tdata[6:0];
                        sel_reg <= s_tdata[7];
                        tre_reg <= s_tdata[23:8];
                        tim_reg <= s_tdata[39:24];
                        cnt_reg <= '0;
                        state_reg <= s_tuser[0] ? S_CALC : S_PHASE;
                    end
                end
                S_PHASE: begin
                    ph_reg    <= 32'(32'(idx_reg) * 32'(phase_step_reg));
                    state_reg <= S_START;
                end
                S_START: state_reg <= S_ROT;
                S_ROT:   if (done_lo) state_reg <= S_IDLE;
                S_CALC: begin
                    if (cnt_reg == TAP_W'(TAPS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DRAIN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == TAP_W'(1)) state_reg <= S_SAT;
                end
                S_SAT: state_reg <= S_SQR;
                S_SQR: state_reg <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_rot_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        done_lo == done_hi) else $error("rotators out of step");
    a_pipe_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pb_valid_reg |-> (state_reg == S_CALC || state_reg == S_DRAIN))
        else $error("product stage active outside pass");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_tvalid_reg && !m_tready) |=> state_reg == S_OUT)
        else $error("result overwrote waiting beat");

endmodule
